// ===== rtl/bfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared types, sizes and microcode ROM of the bitmap font glyph renderer.
// ----------------------------------------------------------------------------
package bfg_pkg;

    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 16;
    localparam int STORE_BYTES      = 4096;
    localparam int TABLE_ENTRIES    = 256;
    localparam int MAX_STRIPS       = 32;

    localparam int STORE_AW = $clog2(STORE_BYTES);
    localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
    localparam int STRIP_W  = $clog2(MAX_STRIPS);
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 3;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_TABLE = 2'd1,
        OP_STORE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        REG_FIRST_CODE    = 3'd0,
        REG_FINAL_CODE    = 3'd1,
        REG_FALLBACK_CODE = 3'd2,
        REG_GLYPH_ROWS    = 3'd3,
        REG_CLIP_LEFT     = 3'd4,
        REG_CLIP_TOP      = 3'd5,
        REG_CLIP_RIGHT    = 3'd6,
        REG_CLIP_BOTTOM   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         char_code;
        logic [4:0]         entry_width;
        logic [11:0]        entry_offset;
        logic [11:0]        store_address;
        logic [7:0]         store_byte;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic               start_string;
        logic               opaque;
        logic [31:0]        fore_color;
        logic [31:0]        back_color;
    } t_in;

    typedef struct packed {
        logic signed [15:0] strip_x;
        logic signed [15:0] strip_y;
        logic [7:0]         fore_mask;
        logic [7:0]         draw_mask;
        logic [4:0]         glyph_width;
        logic [31:0]        fore_out;
        logic [31:0]        back_out;
        logic               last_strip;
    } t_out;

    typedef struct packed {
        logic [4:0]  width;
        logic [11:0] offset;
    } t_tbl_entry;

    localparam int TBL_DW = $bits(t_tbl_entry);

    // datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_WR_TBL,
        ACT_WR_STORE,
        ACT_LOOKUP,
        ACT_LOAD,
        ACT_FETCH,
        ACT_EMIT,
        ACT_EMIT_EMPTY,
        ACT_PEN
    } t_act;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_OP_TABLE,
        C_OP_STORE,
        C_OP_DRAW,
        C_EMPTY,
        C_MORE
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE      = 4'd0;
    localparam t_step ST_DEC_TBL   = 4'd1;
    localparam t_step ST_DEC_STORE = 4'd2;
    localparam t_step ST_DEC_DRAW  = 4'd3;
    localparam t_step ST_DROP      = 4'd4;
    localparam t_step ST_WR_TBL    = 4'd5;
    localparam t_step ST_WR_STORE  = 4'd6;
    localparam t_step ST_LOOKUP    = 4'd7;
    localparam t_step ST_LOAD      = 4'd8;
    localparam t_step ST_FETCH     = 4'd9;
    localparam t_step ST_EMIT      = 4'd10;
    localparam t_step ST_PEN       = 4'd11;
    localparam t_step ST_EMPTY     = 4'd12;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_act act;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic op_table;
        logic op_store;
        logic op_draw;
        logic empty;
        logic last;
    } t_status;

    // microcode: when the condition holds jump to target, else step + 1
    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        case (s)
            ST_IDLE:      w = '{ACT_NONE,       C_NO_START, ST_IDLE};
            ST_DEC_TBL:   w = '{ACT_NONE,       C_OP_TABLE, ST_WR_TBL};
            ST_DEC_STORE: w = '{ACT_NONE,       C_OP_STORE, ST_WR_STORE};
            ST_DEC_DRAW:  w = '{ACT_NONE,       C_OP_DRAW,  ST_LOOKUP};
            ST_DROP:      w = '{ACT_NONE,       C_ALWAYS,   ST_IDLE};
            ST_WR_TBL:    w = '{ACT_WR_TBL,     C_ALWAYS,   ST_IDLE};
            ST_WR_STORE:  w = '{ACT_WR_STORE,   C_ALWAYS,   ST_IDLE};
            ST_LOOKUP:    w = '{ACT_LOOKUP,     C_NEVER,    ST_IDLE};
            ST_LOAD:      w = '{ACT_LOAD,       C_NEVER,    ST_IDLE};
            ST_FETCH:     w = '{ACT_FETCH,      C_EMPTY,    ST_EMPTY};
            ST_EMIT:      w = '{ACT_EMIT,       C_MORE,     ST_EMIT};
            ST_PEN:       w = '{ACT_PEN,        C_ALWAYS,   ST_IDLE};
            ST_EMPTY:     w = '{ACT_EMIT_EMPTY, C_ALWAYS,   ST_PEN};
            default:      w = '{ACT_NONE,       C_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bfg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bfg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module bfg_seq
    import bfg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_busy
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take;

    assign uw = uc_rom(r_step);

    always_comb begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !i_start;
            C_OP_TABLE: take = i_status.op_table;
            C_OP_STORE: take = i_status.op_store;
            C_OP_DRAW:  take = i_status.op_draw;
            C_EMPTY:    take = i_status.empty;
            C_MORE:     take = !i_status.last;
            default:    take = 1'b1;
        endcase
    end

    always_comb begin
        n_step = take ? uw.target : t_step'(r_step + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_ctrl.act    = uw.act;
        o_ctrl.accept = (r_step == ST_IDLE) && i_start;
        o_busy        = (r_step != ST_IDLE);
    end

endmodule

// ===== rtl/bfg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_dp
// Datapath: config registers, glyph table, bitmap store, strip builder.
// ----------------------------------------------------------------------------
module bfg_dp
    import bfg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_status           o_status,
    output t_out              o_result,
    output logic              o_strobe
);

    function automatic logic signed [17:0] sx18(input logic [15:0] v);
        return $signed({{2{v[15]}}, v});
    endfunction

    // configuration
    logic [7:0]         r_first_code;
    logic [7:0]         r_final_code;
    logic [7:0]         r_fallback_code;
    logic [4:0]         r_glyph_rows;
    logic signed [15:0] r_clip_left;
    logic signed [15:0] r_clip_top;
    logic signed [15:0] r_clip_right;
    logic signed [15:0] r_clip_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code    <= 8'd32;
            r_final_code    <= 8'd127;
            r_fallback_code <= 8'd32;
            r_glyph_rows    <= 5'd16;
            r_clip_left     <= 16'sd0;
            r_clip_top      <= 16'sd0;
            r_clip_right    <= 16'sd32767;
            r_clip_bottom   <= 16'sd32767;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FIRST_CODE:    r_first_code    <= i_cfg_data[7:0];
                REG_FINAL_CODE:    r_final_code    <= i_cfg_data[7:0];
                REG_FALLBACK_CODE: r_fallback_code <= i_cfg_data[7:0];
                REG_GLYPH_ROWS:    r_glyph_rows    <= i_cfg_data[4:0];
                REG_CLIP_LEFT:     r_clip_left     <= $signed(i_cfg_data);
                REG_CLIP_TOP:      r_clip_top      <= $signed(i_cfg_data);
                REG_CLIP_RIGHT:    r_clip_right    <= $signed(i_cfg_data);
                REG_CLIP_BOTTOM:   r_clip_bottom   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // working registers
    t_in                 r_item;
    logic [15:0]         r_pen;
    logic                r_idx_ok;
    logic [4:0]          r_width;
    logic [2:0]          r_cols;
    logic [4:0]          r_rows;
    logic [4:0]          r_row;
    logic [1:0]          r_col;
    logic [STRIP_W-1:0]  r_n;
    logic [STORE_AW-1:0] r_addr;
    t_out                r_out;
    logic                r_strobe;

    // code to table index
    logic       code_out;
    logic [7:0] code;
    logic [7:0] idx;

    always_comb begin
        code_out = (r_item.char_code > r_final_code) || (r_item.char_code < r_first_code);
        code     = code_out ? r_fallback_code : r_item.char_code;
        idx      = code - r_first_code;
    end

    // glyph table
    logic [TBL_DW-1:0] tbl_rdata;
    t_tbl_entry        tbl_q;
    t_tbl_entry        tbl_w;
    logic              tbl_we;

    always_comb begin
        tbl_w.width  = (32'(r_item.entry_width) > MAX_GLYPH_WIDTH)
                       ? 5'(MAX_GLYPH_WIDTH) : r_item.entry_width;
        tbl_w.offset = r_item.entry_offset;
        tbl_we       = (i_ctrl.act == ACT_WR_TBL)
                       && (32'(r_item.char_code) < TABLE_ENTRIES);
        tbl_q        = t_tbl_entry'(tbl_rdata);
    end

    bfg_ram #(
        .WIDTH (TBL_DW),
        .DEPTH (TABLE_ENTRIES)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (TABLE_AW'(r_item.char_code)),
        .i_wdata (tbl_w),
        .i_re    (i_ctrl.act == ACT_LOOKUP),
        .i_raddr (TABLE_AW'(idx)),
        .o_rdata (tbl_rdata)
    );

    // bitmap store
    logic [7:0] st_rdata;
    logic       st_we;
    logic       st_re;

    always_comb begin
        st_we = (i_ctrl.act == ACT_WR_STORE)
                && (32'(r_item.store_address) < STORE_BYTES);
        st_re = (i_ctrl.act == ACT_FETCH) || (i_ctrl.act == ACT_EMIT);
    end

    bfg_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (STORE_AW'(r_item.store_address)),
        .i_wdata (r_item.store_byte),
        .i_re    (st_re),
        .i_raddr (r_addr),
        .o_rdata (st_rdata)
    );

    // strip under construction
    logic signed [17:0] x0;
    logic signed [17:0] y;
    logic signed [17:0] xb;
    logic               yin;
    logic [7:0]         valid;
    logic [7:0]         clipm;
    logic [7:0]         fm;
    logic [7:0]         dm;
    logic               row_end;
    logic               last;

    always_comb begin
        x0    = sx18(r_pen) + $signed(18'({r_col, 3'b000}));
        y     = sx18(r_item.origin_y) + $signed(18'(r_row));
        yin   = (y >= sx18(r_clip_top)) && (y < sx18(r_clip_bottom));
        valid = '0;
        clipm = '0;
        xb    = x0;
        for (int b = 0; b < 8; b++) begin
            xb           = x0 + $signed(18'(b));
            valid[7 - b] = (6'({r_col, 3'b000}) + 6'(b)) < 6'(r_width);
            clipm[7 - b] = yin && (xb >= sx18(r_clip_left)) && (xb < sx18(r_clip_right));
        end
        fm      = st_rdata & valid;
        dm      = (r_item.opaque ? valid : fm) & clipm;
        row_end = (r_row == r_rows - 5'd1);
        last    = (row_end && (3'(r_col) == r_cols - 3'd1))
                  || (r_n == STRIP_W'(MAX_STRIPS - 1));
    end

    always_comb begin
        o_status.op_table = (t_op'(r_item.operation) == OP_TABLE);
        o_status.op_store = (t_op'(r_item.operation) == OP_STORE);
        o_status.op_draw  = (t_op'(r_item.operation) == OP_DRAW);
        o_status.empty    = (r_width == 5'd0) || (r_rows == 5'd0);
        o_status.last     = last;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_item <= i_item;
        end
        case (i_ctrl.act)
            ACT_LOOKUP: begin
                r_idx_ok <= (32'(idx) < TABLE_ENTRIES);
            end
            ACT_LOAD: begin
                r_width <= r_idx_ok ? tbl_q.width : 5'd0;
                r_cols  <= r_idx_ok ? 3'((6'(tbl_q.width) + 6'd7) >> 3) : 3'd0;
                r_rows  <= (32'(r_glyph_rows) > MAX_GLYPH_HEIGHT)
                           ? 5'(MAX_GLYPH_HEIGHT) : r_glyph_rows;
                r_addr  <= r_idx_ok ? STORE_AW'(tbl_q.offset) : '0;
                r_row   <= '0;
                r_col   <= '0;
                r_n     <= '0;
            end
            ACT_FETCH: begin
                r_addr <= r_addr + STORE_AW'(1);
            end
            ACT_EMIT: begin
                r_addr <= r_addr + STORE_AW'(1);
                r_n    <= r_n + STRIP_W'(1);
                if (row_end) begin
                    r_row <= '0;
                    r_col <= r_col + 2'd1;
                end else begin
                    r_row <= r_row + 5'd1;
                end
                r_out.strip_x     <= x0[15:0];
                r_out.strip_y     <= y[15:0];
                r_out.fore_mask   <= fm;
                r_out.draw_mask   <= dm;
                r_out.glyph_width <= r_width;
                r_out.fore_out    <= r_item.fore_color;
                r_out.back_out    <= r_item.back_color;
                r_out.last_strip  <= last;
            end
            ACT_EMIT_EMPTY: begin
                r_out.strip_x     <= r_pen;
                r_out.strip_y     <= r_item.origin_y;
                r_out.fore_mask   <= 8'd0;
                r_out.draw_mask   <= 8'd0;
                r_out.glyph_width <= r_width;
                r_out.fore_out    <= r_item.fore_color;
                r_out.back_out    <= r_item.back_color;
                r_out.last_strip  <= 1'b1;
            end
            default: ;
        endcase
    end

    // pen and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen    <= 16'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_ctrl.act == ACT_EMIT) || (i_ctrl.act == ACT_EMIT_EMPTY);
            if ((i_ctrl.act == ACT_LOOKUP) && r_item.start_string) begin
                r_pen <= r_item.origin_x;
            end else if (i_ctrl.act == ACT_PEN) begin
                r_pen <= r_pen + 16'(r_width);
            end
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule

// ===== rtl/bitmap_font_glyph_renderer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_renderer_core
// Bitmap font character generator: glyph table, bitmap store, strip output.
// ----------------------------------------------------------------------------
// Usage:
//  A word on i_item is taken at a clock edge with start high and busy low.
//  Operation table write loads a glyph table entry, bitmap write loads one
//  store byte, the unused code is dropped.
//  A draw looks up the glyph and sends one 8-pixel strip per cycle: column
//  of bytes 0 rows top to bottom, then column 1. The first strip shows on
//  o_result after the decode, lookup, load and fetch steps; a glyph has
//  up to 32 strips, and an empty glyph sends one. The rate is set by the
//  single read port of the bitmap store, one byte per strip.
//  Each strip is valid for one cycle with o_strobe; the receiver cannot
//  stall, so every strobed word must be taken when shown.
//  Config registers are written through i_cfg_we/i_cfg_index/i_cfg_data
//  while the block is idle. Reset restores the register defaults, clears
//  the pen column and idles the sequencer; the glyph table and bitmap
//  store keep no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_renderer_core
    import bfg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_out              o_result,
    output logic              o_strobe
);

    t_ctrl   ctrl;
    t_status status;

    bfg_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    bfg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap font glyph renderer core.
// Loads glyph table entries and bitmap bytes, draws characters under a series
// of register settings, and checks every emitted strip against an in-bench
// prediction of the glyph renderer. Only loaded table entries and store bytes
// are ever read back by a draw.
// ----------------------------------------------------------------------------
module tb_top;
    import bfg_pkg::*;

    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in               cur_word = '0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    t_out              o_result;
    logic              o_strobe;

    bitmap_font_glyph_renderer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cur_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    always #4 i_clk = ~i_clk;

    // register shadows, reset values
    logic [7:0]         cfg_first = 8'd32;
    logic [7:0]         cfg_last = 8'd127;
    logic [7:0]         cfg_fallback = 8'd32;
    logic [4:0]         cfg_rows = 5'd16;
    logic signed [15:0] clip_l = 16'sd0;
    logic signed [15:0] clip_t = 16'sd0;
    logic signed [15:0] clip_r = 16'sd32767;
    logic signed [15:0] clip_b = 16'sd32767;

    // predicted block state, updated as words are accepted
    logic signed [15:0] pen_col = '0;
    logic [4:0]         wid_mem [TABLE_ENTRIES];
    logic [11:0]        off_mem [TABLE_ENTRIES];
    logic [7:0]         font_mem [STORE_BYTES];

    // generator view: what is loaded once every queued word has been taken
    bit                 tbl_ok [TABLE_ENTRIES];
    bit                 byte_ok [STORE_BYTES];
    logic [4:0]         gen_wid [TABLE_ENTRIES];
    logic [11:0]        gen_off [TABLE_ENTRIES];

    t_in  pending_words [$];
    t_out want_strips [$];

    int n_gen = 0;
    int n_draws = 0;
    int n_loads = 0;
    int n_strips = 0;
    int n_settings = 1;
    int mism = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;

    task automatic add_word(input t_in w);
        pending_words = {pending_words, w};
    endtask

    task automatic add_strip(input t_out s);
        want_strips = {want_strips, s};
    endtask

    function automatic logic [7:0] font_index(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c > cfg_last || c < cfg_first)
            c = cfg_fallback;
        return c - cfg_first;
    endfunction

    function automatic int eff_rows();
        return (cfg_rows > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : int'(cfg_rows);
    endfunction

    // -------------------------------------------------------------------------
    // glyph renderer prediction
    // -------------------------------------------------------------------------
    task automatic render_word(input t_in w);
        logic [7:0]  idx;
        logic [4:0]  wid;
        logic [11:0] off;
        logic [11:0] addr;
        logic [7:0]  valid, clipm, fm, m;
        int          rows, cols, x0, y, x;
        bit          yin;
        t_out        s;
        case (t_op'(w.operation))
            OP_TABLE: begin
                wid_mem[w.char_code] = (w.entry_width > MAX_GLYPH_WIDTH) ?
                                       5'(MAX_GLYPH_WIDTH) : w.entry_width;
                off_mem[w.char_code] = w.entry_offset;
                n_loads++;
            end
            OP_STORE: begin
                font_mem[w.store_address] = w.store_byte;
                n_loads++;
            end
            OP_DRAW: begin
                n_draws++;
                if (w.start_string)
                    pen_col = w.origin_x;
                idx  = font_index(w.char_code);
                wid  = wid_mem[idx];
                off  = off_mem[idx];
                rows = eff_rows();
                s.glyph_width = wid;
                s.fore_out    = w.fore_color;
                s.back_out    = w.back_color;
                if (wid == 0 || rows == 0) begin
                    s.strip_x    = pen_col;
                    s.strip_y    = w.origin_y;
                    s.fore_mask  = '0;
                    s.draw_mask  = '0;
                    s.last_strip = 1'b1;
                    add_strip(s);
                end else begin
                    cols = (int'(wid) + 7) >> 3;
                    for (int col = 0; col < cols; col++) begin
                        for (int row = 0; row < rows; row++) begin
                            addr  = off + 12'(col * rows + row);
                            y     = int'(w.origin_y) + row;
                            x0    = int'(pen_col) + col * 8;
                            yin   = (y >= clip_t) && (y < clip_b);
                            valid = '0;
                            clipm = '0;
                            for (int b = 0; b < 8; b++) begin
                                m = 8'h80 >> b;
                                x = x0 + b;
                                if (col * 8 + b < int'(wid))
                                    valid |= m;
                                if (yin && x >= clip_l && x < clip_r)
                                    clipm |= m;
                            end
                            fm = font_mem[addr] & valid;
                            s.strip_x    = x0[15:0];
                            s.strip_y    = y[15:0];
                            s.fore_mask  = fm;
                            s.draw_mask  = (w.opaque ? valid : fm) & clipm;
                            s.last_strip = (col == cols - 1) && (row == rows - 1);
                            add_strip(s);
                        end
                    end
                end
                pen_col = pen_col + wid;
            end
            default: ;
        endcase
    endtask

    // -------------------------------------------------------------------------
    // driver: bursts of words from the pending queue with random gaps
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                render_word(cur_word);
            if (start && busy) begin
                // hold the word until taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_words.size() > 0) begin
                cur_word <= pending_words.pop_front();
                start    <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------------
    // monitor: every strobed strip against the oldest prediction
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out  want;
        string flds;
        if (i_rst_n && o_strobe) begin
            n_strips++;
            if (want_strips.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("%0t: strip with nothing expected: x=%0d y=%0d", $realtime,
                             o_result.strip_x, o_result.strip_y);
            end else begin
                want = want_strips.pop_front();
                flds = "";
                if (o_result.strip_x !== want.strip_x)         flds = {flds, " strip_x"};
                if (o_result.strip_y !== want.strip_y)         flds = {flds, " strip_y"};
                if (o_result.fore_mask !== want.fore_mask)     flds = {flds, " fore_mask"};
                if (o_result.draw_mask !== want.draw_mask)     flds = {flds, " draw_mask"};
                if (o_result.glyph_width !== want.glyph_width) flds = {flds, " glyph_width"};
                if (o_result.fore_out !== want.fore_out)       flds = {flds, " fore_out"};
                if (o_result.back_out !== want.back_out)       flds = {flds, " back_out"};
                if (o_result.last_strip !== want.last_strip)   flds = {flds, " last_strip"};
                if (flds != "") begin
                    mism++;
                    if (mism <= 10) begin
                        $display("%0t: strip %0d mismatch in%s", $realtime, n_strips, flds);
                        $display("  got  x=%0d y=%0d fm=%02h dm=%02h w=%0d fg=%08h bg=%08h last=%0b",
                                 o_result.strip_x, o_result.strip_y, o_result.fore_mask,
                                 o_result.draw_mask, o_result.glyph_width, o_result.fore_out,
                                 o_result.back_out, o_result.last_strip);
                        $display("  want x=%0d y=%0d fm=%02h dm=%02h w=%0d fg=%08h bg=%08h last=%0b",
                                 want.strip_x, want.strip_y, want.fore_mask, want.draw_mask,
                                 want.glyph_width, want.fore_out, want.back_out, want.last_strip);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d strips still due",
                     WATCHDOG_LIMIT, want_strips.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------
    function automatic t_in rand_word();
        t_in w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic logic [4:0] rand_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 5'd0;
        if (r == 1) return 5'($urandom_range(17, 31));
        if (r < 10) return 5'($urandom_range(1, 8));
        return 5'($urandom_range(9, 16));
    endfunction

    function automatic logic [11:0] rand_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 12'($urandom_range(0, 255));
        if (r == 6) return 12'($urandom_range(4064, 4095));
        return 12'($urandom);
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 100) - 20);
        if (r == 7) return 16'($urandom);
        if (r == 8) return 16'($urandom_range(32740, 32767));
        return 16'(-32768 + $urandom_range(0, 20));
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return cfg_first;
                1: return cfg_last;
                2: return cfg_first - 8'd1;
                default: return cfg_last + 8'd1;
            endcase
        end
        if (r < 4 || cfg_first > cfg_last)
            return 8'($urandom);
        return 8'($urandom_range(cfg_first, cfg_last));
    endfunction

    task automatic put_table(input logic [7:0] idx, input logic [4:0] w, input logic [11:0] off);
        t_in x;
        x = rand_word();
        x.operation    = OP_TABLE;
        x.char_code    = idx;
        x.entry_width  = w;
        x.entry_offset = off;
        add_word(x);
        tbl_ok[idx]  = 1'b1;
        gen_wid[idx] = (w > MAX_GLYPH_WIDTH) ? 5'(MAX_GLYPH_WIDTH) : w;
        gen_off[idx] = off;
        n_gen++;
    endtask

    task automatic put_byte(input logic [11:0] addr, input logic [7:0] v);
        t_in x;
        x = rand_word();
        x.operation     = OP_STORE;
        x.store_address = addr;
        x.store_byte    = v;
        add_word(x);
        byte_ok[addr] = 1'b1;
        n_gen++;
    endtask

    task automatic put_nop();
        t_in x;
        x = rand_word();
        x.operation = OP_NOP;
        add_word(x);
    endtask

    // load whatever a draw of this code would read that is not loaded yet
    task automatic ensure_glyph(input logic [7:0] code);
        logic [7:0]  idx;
        logic [11:0] addr;
        int          rows, cols;
        idx = font_index(code);
        if (!tbl_ok[idx])
            put_table(idx, rand_width(), rand_offset());
        if (!byte_ok[gen_off[idx]])
            put_byte(gen_off[idx], 8'($urandom));
        rows = eff_rows();
        cols = (int'(gen_wid[idx]) + 7) >> 3;
        for (int col = 0; col < cols; col++) begin
            for (int row = 0; row < rows; row++) begin
                addr = gen_off[idx] + 12'(col * rows + row);
                if (!byte_ok[addr])
                    put_byte(addr, 8'($urandom));
            end
        end
    endtask

    task automatic put_draw(input logic [7:0] code, input bit ss, input bit opq,
                            input logic [15:0] ox, input logic [15:0] oy);
        t_in x;
        ensure_glyph(code);
        x = rand_word();
        x.operation    = OP_DRAW;
        x.char_code    = code;
        x.start_string = ss;
        x.opaque       = opq;
        x.origin_x     = ox;
        x.origin_y     = oy;
        add_word(x);
        n_gen++;
    endtask

    task automatic random_phase(input int count);
        int          stop, r, len;
        logic [15:0] oy;
        stop = n_gen + count;
        while (n_gen < stop) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                put_table(8'($urandom), rand_width(), rand_offset());
            end else if (r < 16) begin
                put_byte(rand_offset(), 8'($urandom));
            end else if (r < 19) begin
                put_nop();
            end else begin
                // one text line: pen loaded on the first character
                len = $urandom_range(1, 6);
                oy  = rand_coord();
                for (int k = 0; k < len; k++)
                    put_draw(pick_code(), (k == 0) || ($urandom_range(0, 7) == 0),
                             1'($urandom_range(0, 1)), rand_coord(), oy);
            end
        end
    endtask

    // wait for every queued word to be taken and the block to go quiet;
    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || start || busy || want_strips.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        case (r)
            REG_FIRST_CODE:    cfg_first = v[7:0];
            REG_FINAL_CODE:    cfg_last = v[7:0];
            REG_FALLBACK_CODE: cfg_fallback = v[7:0];
            REG_GLYPH_ROWS:    cfg_rows = v[4:0];
            REG_CLIP_LEFT:     clip_l = v;
            REG_CLIP_TOP:      clip_t = v;
            REG_CLIP_RIGHT:    clip_r = v;
            REG_CLIP_BOTTOM:   clip_b = v;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // unused upper data bits carry random junk
    task automatic set_config(input logic [7:0] fst, input logic [7:0] lst,
                              input logic [7:0] fb, input logic [4:0] rows,
                              input logic [15:0] cl, input logic [15:0] ct,
                              input logic [15:0] cr, input logic [15:0] cb);
        write_reg(REG_FIRST_CODE,    {8'($urandom), fst});
        write_reg(REG_FINAL_CODE,    {8'($urandom), lst});
        write_reg(REG_FALLBACK_CODE, {8'($urandom), fb});
        write_reg(REG_GLYPH_ROWS,    {11'($urandom), rows});
        write_reg(REG_CLIP_LEFT,     cl);
        write_reg(REG_CLIP_TOP,      ct);
        write_reg(REG_CLIP_RIGHT,    cr);
        write_reg(REG_CLIP_BOTTOM,   cb);
        n_settings++;
    endtask

    // -------------------------------------------------------------------------
    // test sequence
    // -------------------------------------------------------------------------
    initial begin
        logic [7:0] fst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default codes and clip, two-row glyphs keep the loads short
        write_reg(REG_GLYPH_ROWS, 16'd2);
        put_table(8'd33, 5'd16, 12'd0);         // 'A', two byte columns
        put_byte(12'd0, 8'hFF);
        put_byte(12'd1, 8'h00);
        put_byte(12'd2, 8'h81);
        put_byte(12'd3, 8'h7E);
        put_table(8'd0, 5'd0, 12'd4095);        // space: empty glyph, also the fallback
        put_byte(12'd4095, 8'hA5);
        put_table(8'd95, 5'd31, 12'd4094);      // oversized width, store wraps
        put_byte(12'd4094, 8'h3C);
        put_table(8'd34, 5'd5, 12'd100);        // narrow glyph
        put_draw(8'd65, 1'b1, 1'b0, 16'd0, 16'd0);
        put_draw(8'd65, 1'b0, 1'b1, 16'd0, 16'd0);
        put_draw(8'd127, 1'b0, 1'b0, 16'd0, 16'd1);
        put_draw(8'd32, 1'b0, 1'b1, 16'd0, 16'd2);
        put_draw(8'd0, 1'b0, 1'b0, 16'd0, 16'd2);       // below range
        put_draw(8'd255, 1'b0, 1'b1, 16'd0, 16'd2);     // above range
        put_draw(8'd66, 1'b1, 1'b1, 16'hFFFC, 16'hFFFF); // clipped at left and top
        put_nop();
        put_draw(8'd65, 1'b1, 1'b1, 16'h8000, 16'h7FFF);
        put_draw(8'd65, 1'b1, 1'b1, 16'h7FF8, 16'd5);   // pen wraps past the top
        put_draw(8'd66, 1'b0, 1'b0, 16'd0, 16'd5);
        wait_idle();

        set_config(8'd0, 8'd255, 8'd0, 5'd8, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        random_phase(70);
        wait_idle();

        // fallback itself outside the font range
        set_config(8'd32, 8'd126, 8'd200, 5'd16, 16'd10, 16'd5, 16'd60, 16'd40);
        random_phase(70);
        wait_idle();

        // empty range and empty clip; rows above the maximum
        set_config(8'd200, 8'd50, 8'd7, 5'd31, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        random_phase(60);
        wait_idle();

        // zero rows: every draw is an empty glyph
        set_config(8'd32, 8'd127, 8'd32, 5'd0, 16'd0, 16'd0, 16'd100, 16'd100);
        random_phase(50);
        wait_idle();

        set_config(8'd255, 8'd255, 8'd0, 5'd1, 16'd32760, 16'hFFFB, 16'h7FFF, 16'h7FFF);
        random_phase(60);
        wait_idle();

        fst = 8'($urandom_range(0, 128));
        set_config(fst, 8'($urandom_range(fst, 255)), 8'($urandom), 5'($urandom_range(1, 16)),
                   16'($urandom_range(0, 50) - 20), 16'($urandom_range(0, 50) - 20),
                   16'($urandom_range(30, 100)), 16'($urandom_range(30, 100)));
        random_phase(80);
        wait_idle();

        if (want_strips.size() != 0) begin
            $display("%0d expected strips never arrived", want_strips.size());
            mism += want_strips.size();
        end
        $display("Covered %0d draws and %0d table/bitmap loads under %0d register settings,",
                 n_draws, n_loads, n_settings);
        $display("%0d strips checked, %0d mismatches", n_strips, mism);
        if (mism == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bfg_pkg.sv
rtl/bfg_ram.sv
rtl/bfg_seq.sv
rtl/bfg_dp.sv
rtl/bitmap_font_glyph_renderer_core.sv
bench/tb_top.sv
